@@ hdl/ffra_pkg.sv @@
// Shared types and constants for the first-fit region allocator.
// No dependencies.
`default_nettype none
package ffra_pkg;
    localparam int unsigned MaxBlocksDefault = 64;
    localparam int unsigned AlignBytesDefault = 8;
    localparam int unsigned SzW = 17;
    localparam int unsigned AddrW = 32;
    localparam int unsigned CfgIdxW = 1;
    localparam logic [SzW-1:0] RegionLimit = 17'h10000;

    typedef enum logic [1:0] {
        K_ALLOC = 2'd0,
        K_FREE  = 2'd1,
        K_QUERY = 2'd2,
        K_NONE  = 2'd3
    } t_kind;

    localparam logic [CfgIdxW-1:0] CFG_REGION = 1'b0;
    localparam logic [CfgIdxW-1:0] CFG_BASE   = 1'b1;

    typedef struct packed {
        logic [1:0]       kind;
        logic [SzW-1:0]   request_bytes;
        logic [AddrW-1:0] block_address;
    } t_req;

    typedef struct packed {
        logic [AddrW-1:0] result_address;
        logic             ok;
        logic [SzW-1:0]   block_bytes;
        logic [SzW-1:0]   used_total;
    } t_rsp;
endpackage
`default_nettype wire

@@ hdl/ffra_if.sv @@
// Valid/ready channel interfaces for requests and responses.
// Depends on ffra_pkg.
`default_nettype none
interface ffra_req_if;
    logic valid;
    logic ready;
    ffra_pkg::t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface ffra_rsp_if;
    logic valid;
    logic ready;
    ffra_pkg::t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ hdl/first_fit_region_allocator.sv @@
// Top level of the first-fit region allocator: sequencer around the table.
// Depends on ffra_pkg, ffra_if and ffra_table.
// The table walk and the shift of entries step through the table one entry at a
// time, using its registered read port and its separate write port.
// One item at a time; the next request transfer may be taken while a result
// waits in the output register. Reset is synchronous; it empties the table,
// clears used bytes and sets the region to 65536 bytes at base zero.
`default_nettype none
module first_fit_region_allocator #(
    parameter int unsigned MAX_BLOCKS = ffra_pkg::MaxBlocksDefault,
    parameter int unsigned ALIGN_BYTES = ffra_pkg::AlignBytesDefault
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [ffra_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  wire logic [ffra_pkg::AddrW-1:0]    i_cfg_data,
    ffra_req_if.sink                           i_req,
    ffra_rsp_if.source                         o_rsp
);
    import ffra_pkg::*;
    localparam int unsigned IW = $clog2(MAX_BLOCKS);
    localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [CW-1:0] CMax = CW'(MAX_BLOCKS);
    localparam logic [SzW:0] AlignM1 = (SzW+1)'(ALIGN_BYTES - 1);
    localparam logic [SzW:0] AlignK = (SzW+1)'(ALIGN_BYTES);
    localparam int unsigned RcpSh = 25;
    localparam longint unsigned AlignRcpL =
        ((64'd1 << RcpSh) + 64'(ALIGN_BYTES) - 64'd1) / 64'(ALIGN_BYTES);
    localparam logic [RcpSh:0] AlignRcp = (RcpSh+1)'(AlignRcpL);

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_CHK, S_SHRD, S_SHWR, S_INS, S_DLRD, S_DLWR, S_OUT
    } t_state;

    t_state r_state;
    logic [SzW-1:0] r_region, r_used;
    logic [AddrW-1:0] r_base;
    logic [CW-1:0] r_count, r_i, r_pos;
    t_req r_req;
    logic [SzW:0] r_need, r_last;
    logic [AddrW-1:0] r_off;
    logic r_full;
    t_rsp r_rsp;
    t_rsp r_out;
    logic r_ovalid;

    logic tw_we;
    logic [IW-1:0] tw_addr, tr_addr;
    logic [2*SzW-1:0] tw_data, tr_data;

    // Rounds down to a multiple of the alignment by reciprocal multiplication.
    function automatic logic [SzW:0] align_down(input logic [SzW:0] x);
        logic [SzW+RcpSh+1:0] prod;
        logic [SzW:0] quo;
        logic [2*SzW+1:0] back;
        prod = {{(RcpSh+1){1'b0}}, x} * {{(SzW+1){1'b0}}, AlignRcp};
        quo = prod[SzW+RcpSh:RcpSh];
        back = {{(SzW+1){1'b0}}, quo} * {{(SzW+1){1'b0}}, AlignK};
        return back[SzW:0];
    endfunction

    ffra_table #(.MAX_BLOCKS(MAX_BLOCKS)) u_table (
        .i_clk(i_clk), .i_we(tw_we), .i_waddr(tw_addr), .i_wdata(tw_data),
        .i_raddr(tr_addr), .o_rdata(tr_data)
    );

    logic [SzW:0] e_start, e_size, e_end, reg_use;
    assign e_start = {1'b0, tr_data[2*SzW-1:SzW]};
    assign e_size  = {1'b0, tr_data[SzW-1:0]};
    assign e_end   = e_start + e_size;
    always_comb begin
        logic [SzW:0] r;
        r = (r_region > RegionLimit) ? {1'b0, RegionLimit} : {1'b0, r_region};
        reg_use = align_down(r);
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.payload = r_out;

    always_comb begin
        tw_we = 1'b0;
        tw_addr = r_i[IW-1:0];
        tw_data = tr_data;
        tr_addr = r_i[IW-1:0];
        case (r_state)
            S_SHRD: tr_addr = IW'(r_i - 1'b1);
            S_SHWR: tw_we = 1'b1;
            S_INS: begin
                tw_we = 1'b1;
                tw_addr = r_pos[IW-1:0];
                tw_data = {r_last[SzW-1:0], r_need[SzW-1:0]};
            end
            S_DLRD: tr_addr = IW'(r_i + 1'b1);
            S_DLWR: tw_we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_region <= RegionLimit;
            r_base <= '0;
            r_count <= '0;
            r_used <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_REGION: r_region <= i_cfg_data[SzW-1:0];
                    CFG_BASE: r_base <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_ovalid && o_rsp.ready && r_state != S_OUT) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid && i_req.ready) begin
                        r_req <= i_req.payload;
                        r_need <= align_down({1'b0, i_req.payload.request_bytes}
                                             + AlignM1);
                        r_off <= i_req.payload.block_address - r_base;
                        r_last <= '0;
                        r_i <= '0;
                        r_rsp <= '0;
                        r_full <= (r_count >= CMax);
                        r_state <= (r_count == 0) ? S_CHK : S_RD;
                    end
                end
                S_RD: r_state <= S_CHK;
                S_CHK: begin
                    if (r_req.kind == K_ALLOC) begin
                        if (r_i == r_count || (e_start >= r_last
                                && e_start - r_last >= r_need)) begin
                            r_pos <= r_i;
                            if (r_need == 0 || r_full || r_last > reg_use
                                    || reg_use - r_last < r_need) begin
                                r_state <= S_OUT;
                            end else begin
                                r_i <= r_count;
                                r_state <= (r_count == r_i) ? S_INS : S_SHRD;
                            end
                        end else begin
                            r_last <= e_end;
                            r_i <= r_i + 1'b1;
                            r_state <= (r_i + 1'b1 == r_count) ? S_CHK : S_RD;
                        end
                    end else if (r_req.kind == K_FREE || r_req.kind == K_QUERY) begin
                        if (r_i == r_count) begin
                            r_state <= S_OUT;
                        end else if (r_off[AddrW-1:SzW] == 0
                                && e_start[SzW-1:0] == r_off[SzW-1:0]) begin
                            r_rsp.ok <= 1'b1;
                            r_rsp.block_bytes <= e_size[SzW-1:0];
                            if (r_req.kind == K_FREE) begin
                                r_used <= (r_used >= e_size[SzW-1:0])
                                          ? r_used - e_size[SzW-1:0] : '0;
                                r_count <= r_count - 1'b1;
                                r_state <= (r_i + 1'b1 >= r_count) ? S_OUT : S_DLRD;
                            end else begin
                                r_state <= S_OUT;
                            end
                        end else begin
                            r_i <= r_i + 1'b1;
                            r_state <= (r_i + 1'b1 == r_count) ? S_CHK : S_RD;
                        end
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_SHRD: r_state <= S_SHWR;
                S_SHWR: begin
                    r_i <= r_i - 1'b1;
                    r_state <= (r_i - 1'b1 == r_pos) ? S_INS : S_SHRD;
                end
                S_INS: begin
                    r_count <= r_count + 1'b1;
                    r_used <= ({1'b0, r_used} + r_need > {1'b0, RegionLimit})
                              ? RegionLimit : SzW'({1'b0, r_used} + r_need);
                    r_rsp.ok <= 1'b1;
                    r_rsp.block_bytes <= r_need[SzW-1:0];
                    r_rsp.result_address <= r_base + AddrW'(r_last);
                    r_state <= S_OUT;
                end
                S_DLRD: r_state <= S_DLWR;
                S_DLWR: begin
                    r_i <= r_i + 1'b1;
                    r_state <= (r_i + 1'b1 >= r_count) ? S_OUT : S_DLRD;
                end
                S_OUT: begin
                    if (!r_ovalid || o_rsp.ready) begin
                        r_out <= {r_rsp.result_address, r_rsp.ok,
                                  r_rsp.block_bytes, r_used};
                        r_ovalid <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

@@ hdl/ffra_table.sv @@
// Block table memory: one synchronous entry store of start and size pairs.
// Depends on ffra_pkg.
`default_nettype none
module ffra_table #(
    parameter int unsigned MAX_BLOCKS = ffra_pkg::MaxBlocksDefault,
    localparam int unsigned IW = $clog2(MAX_BLOCKS)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [IW-1:0]            i_waddr,
    input  wire logic [2*ffra_pkg::SzW-1:0] i_wdata,
    input  wire logic [IW-1:0]            i_raddr,
    output logic [2*ffra_pkg::SzW-1:0]    o_rdata
);
    import ffra_pkg::*;
    logic [2*SzW-1:0] mem [MAX_BLOCKS];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire
